// ===== hw/rtl/ipv4fhc_pkg.sv =====
// Shared types and constants for the IPv4 frame header classifier.
package ipv4fhc_pkg;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_WEB_PORT          = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_NAME_SERVICE_PORT = 1'd1;
   localparam int unsigned CsrDataWidth = 16;

   // Configuration reset values
   localparam logic [15:0] WEB_PORT_RESET          = 16'd80;
   localparam logic [15:0] NAME_SERVICE_PORT_RESET = 16'd53;

   // Header constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
   localparam logic [6:0]  ETH_HEADER_BYTES = 7'd14;

   // Protocol class codes
   typedef enum logic [2:0] {
      CLASS_UNKNOWN = 3'd0,
      CLASS_TCP     = 3'd1,
      CLASS_UDP     = 3'd2,
      CLASS_ICMP    = 3'd3,
      CLASS_HTTP    = 3'd4,
      CLASS_DNS     = 3'd5
   } class_type;

   // One request: a frame byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // One response: a frame summary
   typedef struct packed {
      logic [31:0] frame_number;
      logic [15:0] frame_length;
      logic [2:0]  protocol_class;
      logic [5:0]  ip_header_bytes;
      logic [7:0]  ip_protocol;
      logic [7:0]  ip_ttl;
      logic [15:0] ip_total_length;
      logic [31:0] source_address;
      logic [31:0] dst_address;
      logic [15:0] source_port;
      logic [15:0] dst_port;
      logic [15:0] transport_detail;
   } rsp_payload_type;

   // Frame captures including the byte now in the input register
   typedef struct packed {
      logic        last_byte;
      logic [15:0] frame_length;
      logic [15:0] ether_kind;
      logic [3:0]  ihl;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [15:0] total_length;
      logic [31:0] source_addr;
      logic [31:0] dst_addr;
      logic [15:0] first_port;
      logic [15:0] second_port;
      logic [7:0]  tcp_flags;
   } frame_view_type;

endpackage

// ===== hw/rtl/ipv4fhc_capture.sv =====
// Per-frame header capture: byte position tracking and field registers.
module ipv4fhc_capture (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   output ipv4fhc_pkg::frame_view_type view
);
   import ipv4fhc_pkg::*;

   logic [15:0] byte_offset_ff, byte_offset_in;
   logic [15:0] ether_kind_ff, ether_kind_in;
   logic [7:0]  version_ihl_ff, version_ihl_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [31:0] source_addr_ff, source_addr_in;
   logic [31:0] dst_addr_ff, dst_addr_in;
   logic [15:0] first_port_ff, first_port_in;
   logic [15:0] second_port_ff, second_port_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] pos_next;
   logic [6:0]  l4_start;
   logic [15:0] l4_rel;

   // Fixed-position header fields
   always_comb begin
      ether_kind_in   = ether_kind_ff;
      version_ihl_in  = version_ihl_ff;
      ttl_in          = ttl_ff;
      protocol_in     = protocol_ff;
      total_length_in = total_length_ff;
      source_addr_in  = source_addr_ff;
      dst_addr_in     = dst_addr_ff;
      case (byte_offset_ff)
         16'd12: ether_kind_in[15:8]  = data_byte;
         16'd13: ether_kind_in[7:0]   = data_byte;
         16'd14: version_ihl_in       = data_byte;
         16'd16: total_length_in[15:8] = data_byte;
         16'd17: total_length_in[7:0]  = data_byte;
         16'd22: ttl_in               = data_byte;
         16'd23: protocol_in          = data_byte;
         16'd26: source_addr_in[31:24] = data_byte;
         16'd27: source_addr_in[23:16] = data_byte;
         16'd28: source_addr_in[15:8]  = data_byte;
         16'd29: source_addr_in[7:0]   = data_byte;
         16'd30: dst_addr_in[31:24]    = data_byte;
         16'd31: dst_addr_in[23:16]    = data_byte;
         16'd32: dst_addr_in[15:8]     = data_byte;
         16'd33: dst_addr_in[7:0]      = data_byte;
         default: ;
      endcase
   end

   // Layer-4 header fields, placed by the (possibly just captured) IHL
   assign l4_start = ETH_HEADER_BYTES + {1'b0, version_ihl_in[3:0], 2'b00};
   assign l4_rel   = byte_offset_ff - {9'd0, l4_start};

   always_comb begin
      first_port_in  = first_port_ff;
      second_port_in = second_port_ff;
      flags_in       = flags_ff;
      if (byte_offset_ff >= {9'd0, l4_start}) begin
         case (l4_rel)
            16'd0:  first_port_in[15:8]  = data_byte;
            16'd1:  first_port_in[7:0]   = data_byte;
            16'd2:  second_port_in[15:8] = data_byte;
            16'd3:  second_port_in[7:0]  = data_byte;
            16'd13: flags_in             = data_byte;
            default: ;
         endcase
      end
   end

   // Saturating position; it is also the frame length so far
   assign pos_next = (byte_offset_ff == OFFSET_MAX) ? OFFSET_MAX : byte_offset_ff + 16'd1;
   assign byte_offset_in = pos_next;

   // Updated view for the classifier
   always_comb begin
      view.last_byte    = last_byte;
      view.frame_length = pos_next;
      view.ether_kind   = ether_kind_in;
      view.ihl          = version_ihl_in[3:0];
      view.ttl          = ttl_in;
      view.protocol     = protocol_in;
      view.total_length = total_length_in;
      view.source_addr  = source_addr_in;
      view.dst_addr     = dst_addr_in;
      view.first_port   = first_port_in;
      view.second_port  = second_port_in;
      view.tcp_flags    = flags_in;
   end

   // Frame state; cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         byte_offset_ff  <= '0;
         ether_kind_ff   <= '0;
         version_ihl_ff  <= '0;
         ttl_ff          <= '0;
         protocol_ff     <= '0;
         total_length_ff <= '0;
         source_addr_ff  <= '0;
         dst_addr_ff     <= '0;
         first_port_ff   <= '0;
         second_port_ff  <= '0;
         flags_ff        <= '0;
      end else if (advance) begin
         byte_offset_ff  <= byte_offset_in;
         ether_kind_ff   <= ether_kind_in;
         version_ihl_ff  <= version_ihl_in;
         ttl_ff          <= ttl_in;
         protocol_ff     <= protocol_in;
         total_length_ff <= total_length_in;
         source_addr_ff  <= source_addr_in;
         dst_addr_ff     <= dst_addr_in;
         first_port_ff   <= first_port_in;
         second_port_ff  <= second_port_in;
         flags_ff        <= flags_in;
      end
   end

endmodule

// ===== hw/rtl/ipv4fhc_classify.sv =====
// Frame classification and summary assembly.
module ipv4fhc_classify (
   input  ipv4fhc_pkg::frame_view_type  view,
   input  logic [15:0]                  web_port,
   input  logic [15:0]                  name_service_port,
   input  logic [31:0]                  frame_number,
   output logic                         emit,
   output ipv4fhc_pkg::rsp_payload_type summary
);
   import ipv4fhc_pkg::*;

   class_type   cls;
   logic [15:0] sp, dp, det;

   // Only IPv4 frames produce a summary
   assign emit = view.last_byte && (view.ether_kind == ETHERTYPE_IPV4);

   // Class, ports and detail by IP protocol
   always_comb begin
      cls = CLASS_UNKNOWN;
      sp  = '0;
      dp  = '0;
      det = '0;
      case (view.protocol)
         IP_PROTO_ICMP: begin
            cls = CLASS_ICMP;
            det = view.first_port;
         end
         IP_PROTO_TCP: begin
            sp  = view.first_port;
            dp  = view.second_port;
            cls = (sp == web_port || dp == web_port) ? CLASS_HTTP : CLASS_TCP;
            det = {10'd0, view.tcp_flags[5:0]};
         end
         IP_PROTO_UDP: begin
            sp  = view.first_port;
            dp  = view.second_port;
            cls = (sp == name_service_port || dp == name_service_port) ? CLASS_DNS
                                                                       : CLASS_UDP;
         end
         default: ;
      endcase
   end

   always_comb begin
      summary.frame_number     = frame_number;
      summary.frame_length     = view.frame_length;
      summary.protocol_class   = cls;
      summary.ip_header_bytes  = {view.ihl, 2'b00};
      summary.ip_protocol      = view.protocol;
      summary.ip_ttl           = view.ttl;
      summary.ip_total_length  = view.total_length;
      summary.source_address   = view.source_addr;
      summary.dst_address      = view.dst_addr;
      summary.source_port      = sp;
      summary.dst_port         = dp;
      summary.transport_detail = det;
   end

endmodule

// ===== hw/rtl/ipv4_frame_header_classifier_top.sv =====
// Top level of the IPv4 frame header classifier: channel registers and CSRs.
//
//   channel | direction | signals                        | moves
//   req     | in        | req_valid req_ready req_payload| one frame byte per request
//   rsp     | out       | rsp_valid rsp_ready rsp_payload| one IPv4 frame summary
//   csr     | in        | csr_we csr_index csr_wdata     | port register writes
//
// One byte per cycle while no held summary stalls it; each byte waits in the input
// register, where capture and classification run, and a frame's summary is loaded
// from there into the output register, which presents it.
// Reset clears all frame state, sets the frame number to 1 and the ports to 80/53.
// A held summary stalls only a following summary-producing byte; other bytes flow.
module ipv4_frame_header_classifier_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  ipv4fhc_pkg::req_payload_type              req_payload,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output ipv4fhc_pkg::rsp_payload_type              rsp_payload,
   input  logic                                      csr_we,
   input  logic [ipv4fhc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [ipv4fhc_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import ipv4fhc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic [15:0]     web_port_ff;
   logic [15:0]     ns_port_ff;
   logic [31:0]     frame_number_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   frame_view_type  view;
   rsp_payload_type summary;
   logic            emit;
   logic            advance;
   logic            load_rsp;
   logic            req_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         web_port_ff <= WEB_PORT_RESET;
         ns_port_ff  <= NAME_SERVICE_PORT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WEB_PORT:          web_port_ff <= csr_wdata;
            CSR_NAME_SERVICE_PORT: ns_port_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance: a summary byte waits only while the output is full
   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign load_rsp  = advance && emit;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Input register
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_payload.data_byte;
         in_last_ff <= req_payload.last_byte;
      end
   end

   ipv4fhc_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .view      (view)
   );

   ipv4fhc_classify u_classify (
      .view              (view),
      .web_port          (web_port_ff),
      .name_service_port (ns_port_ff),
      .frame_number      (frame_number_ff),
      .emit              (emit),
      .summary           (summary)
   );

   // Running frame number, advanced per emitted summary
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_number_ff <= 32'd1;
      end else if (load_rsp) begin
         frame_number_ff <= frame_number_ff + 32'd1;
      end
   end

   // Output register
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_payload_ff <= summary;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Frame number steps by one with each loaded summary
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> frame_number_ff == $past(frame_number_ff) + 32'd1)
      else $error("frame number did not advance on summary load");

   // Loaded summary carries the frame number it was stamped with
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_payload_ff.frame_number == frame_number_ff - 32'd1)
      else $error("summary frame number mismatch");

   // Summaries never lose a byte count and classes stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.frame_length != 16'd0) &&
                       (rsp_payload_ff.protocol_class <= CLASS_DNS))
      else $error("summary fields out of range");

   // Input stage blocks only with a byte held that cannot move
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && emit && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without cause");

endmodule
